[src/tli_pkg.sv]
// ----------------------------------------------------------------------------
// Three-table interpolator package
// Shared widths, codes, payload types and the controller state type.
// ----------------------------------------------------------------------------
package tli_pkg;

    // Field widths.
    localparam int VAL_W       = 31;
    localparam int VOLT_W      = 32;
    localparam int TAG_W       = 3;
    localparam int IDX_IN_W    = 11;
    localparam int PROD_W      = 2 * VAL_W;
    localparam int DIFF_W      = VOLT_W + 2;

    // Serial divider: one quotient bit per cycle.
    localparam int DIV_STEPS   = VAL_W;
    localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

    // Table lanes inside one memory word.
    localparam int NUM_TBL     = 3;
    localparam int LANE_GAIN   = 0;
    localparam int LANE_ALPHA  = 1;
    localparam int LANE_ATTEN  = 2;

    localparam int DEF_TABLE_SIZE = 1024;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_VOLT  = 1'b1;

    // Item modes.
    localparam logic MODE_LOAD   = 1'b0;
    localparam logic MODE_LOOKUP = 1'b1;

    // One memory word holds the entry of all three tables.
    typedef logic [NUM_TBL-1:0][VAL_W-1:0] t_tli_entry;

    typedef struct packed {
        logic                     mode;
        logic [IDX_IN_W-1:0]      entry_index;
        logic [VAL_W-1:0]         gain_entry;
        logic [VAL_W-1:0]         alpha_entry;
        logic [VAL_W-1:0]         atten_entry;
        logic signed [VOLT_W-1:0] source_volt;
        logic signed [VOLT_W-1:0] gate_volt;
        logic signed [VOLT_W-1:0] gate_offset;
        logic [TAG_W-1:0]         filter_tag;
    } t_tli_in;

    typedef struct packed {
        logic [VAL_W-1:0] gain_out;
        logic [VAL_W-1:0] alpha_out;
        logic [VAL_W-1:0] atten_out;
        logic [TAG_W-1:0] result_tag;
    } t_tli_out;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POS,
        S_POS_WAIT,
        S_RD_BASE,
        S_RD_NEXT,
        S_DELTA,
        S_MULT,
        S_FRAC,
        S_FRAC_WAIT
    } t_tli_state;

endpackage

[src/tli_mem.sv]
// ----------------------------------------------------------------------------
// Table memory
// Single write port, single read port with a registered read.
// ----------------------------------------------------------------------------
module tli_mem
    import tli_pkg::*;
#(
    parameter int DEPTH  = DEF_TABLE_SIZE + 1,
    parameter int ADDR_W = $clog2(DEF_TABLE_SIZE + 1)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  t_tli_entry        i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output t_tli_entry        o_rdata
);

    t_tli_entry r_mem [DEPTH];
    t_tli_entry r_rdata;

    // Write and registered read.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[src/tli_div.sv]
// ----------------------------------------------------------------------------
// Serial divider
// Restoring division, one quotient bit per cycle. The upper half of the
// dividend must be below the divisor, so the quotient fits in VAL_W bits.
// ----------------------------------------------------------------------------
module tli_div
    import tli_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [PROD_W-1:0] i_num,
    input  logic [VAL_W-1:0]  i_den,
    output logic              o_done,
    output logic [VAL_W-1:0]  o_quo,
    output logic [VAL_W-1:0]  o_rem
);

    logic                 r_run;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [VAL_W-1:0]     r_rem;
    logic [VAL_W-1:0]     r_lo;
    logic [VAL_W-1:0]     r_den;

    logic [VAL_W:0]       n_trial;
    logic                 n_bit;
    logic [VAL_W-1:0]     n_rem;

    // One trial subtraction per cycle.
    always_comb begin
        n_trial = {r_rem, r_lo[VAL_W-1]};
        n_bit   = (n_trial >= {1'b0, r_den});
        if (n_bit) begin
            n_rem = VAL_W'(n_trial - {1'b0, r_den});
        end else begin
            n_rem = n_trial[VAL_W-1:0];
        end
    end

    // Step counter and completion flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and dividend/quotient shift register.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[PROD_W-1:VAL_W];
            r_lo  <= i_num[VAL_W-1:0];
            r_den <= i_den;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_lo  <= {r_lo[VAL_W-2:0], n_bit};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_lo;
    assign o_rem  = r_rem;

endmodule

[src/three_table_linear_interpolator.sv]
// ----------------------------------------------------------------------------
// Three-table linear interpolator
// Holds gain, alpha and attenuation tables and interpolates all three at a
// position derived from a voltage difference.
//
// Usage:
//   Input items are taken on i_item when start is high and busy is low.
//   A load item writes one entry of all three tables in the cycle it is
//   taken and leaves busy low, so loads may follow one another every cycle.
//   A lookup item raises busy and returns one transaction on o_result,
//   marked by o_result_valid for exactly one cycle; busy drops in the same
//   cycle as the strobe. A lookup runs two passes through the bit-serial
//   divider (31 steps each): one for the table position and one, three
//   lanes wide, for the interpolation fraction; between them come the two
//   reads of the single memory port, a subtract and a multiply, and the
//   result register follows the second pass.
//   Configuration goes through i_cfg_we, i_cfg_idx and i_cfg_wdata and must
//   only be written while busy is low. The receiver cannot stall results.
//   Reset sets step_size to 1 and max_volt to 0 and returns to idle; table
//   contents are not cleared and must be loaded before they are looked up.
// ----------------------------------------------------------------------------
module three_table_linear_interpolator
    import tli_pkg::*;
#(
    parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 start,
    output logic                 busy,
    input  t_tli_in              i_item,
    output t_tli_out             o_result,
    output logic                 o_result_valid,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [VAL_W-1:0]     i_cfg_wdata
);

    localparam int DEPTH  = TABLE_SIZE + 1;
    localparam int ADDR_W = $clog2(DEPTH);

    t_tli_state          r_state;
    t_tli_state          n_state;

    logic [VAL_W-1:0]    r_step_size;
    logic [VAL_W-1:0]    r_max_volt;

    logic [VAL_W-1:0]    r_dif;
    logic [VAL_W-1:0]    r_step;
    logic [TAG_W-1:0]    r_tag;
    logic [ADDR_W-1:0]   r_pos;
    logic [ADDR_W-1:0]   r_nxt;
    logic [VAL_W-1:0]    r_frac;
    logic                r_result_valid;
    logic [TAG_W-1:0]    r_result_tag;

    logic                w_accept;
    logic                w_load;
    logic                w_pos_start;
    logic                w_frac_start;
    logic [ADDR_W-1:0]   w_raddr;
    t_tli_entry          w_wdata;
    t_tli_entry          w_rdata;
    t_tli_entry          w_out_val;

    logic signed [DIFF_W-1:0] w_diff;
    logic [VAL_W-1:0]    w_dif_clamp;
    logic                w_pos_clamp;
    logic [ADDR_W-1:0]   w_pos;

    logic [NUM_TBL-1:0]  w_done;
    logic [VAL_W-1:0]    w_quo [NUM_TBL];
    logic [VAL_W-1:0]    w_rem [NUM_TBL];

    // Handshake.
    assign busy     = (r_state != S_IDLE);
    assign w_accept = start && !busy;
    assign w_load   = w_accept && (i_item.mode == MODE_LOAD)
                      && (32'(i_item.entry_index) <= 32'(TABLE_SIZE));

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step_size <= VAL_W'(1);
            r_max_volt  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_STEP_SIZE: r_step_size <= i_cfg_wdata;
                CFG_MAX_VOLT:  r_max_volt  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Voltage difference, clamped to the range 0 to max_volt.
    always_comb begin
        w_diff = DIFF_W'($signed(i_item.source_volt))
                 - DIFF_W'($signed(i_item.gate_volt))
                 - DIFF_W'($signed(i_item.gate_offset));
        if (w_diff[DIFF_W-1]) begin
            w_dif_clamp = '0;
        end else if (w_diff[DIFF_W-2:0] > (DIFF_W-1)'(r_max_volt)) begin
            w_dif_clamp = r_max_volt;
        end else begin
            w_dif_clamp = w_diff[VAL_W-1:0];
        end
    end

    // Table position from the first division, clamped to the last entry.
    assign w_pos_clamp = (w_quo[LANE_GAIN] > VAL_W'(TABLE_SIZE));
    assign w_pos       = w_pos_clamp ? ADDR_W'(TABLE_SIZE) : ADDR_W'(w_quo[LANE_GAIN]);

    // Lookup item capture and position registers.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_dif  <= w_dif_clamp;
            r_step <= (r_step_size == '0) ? VAL_W'(1) : r_step_size;
            r_tag  <= i_item.filter_tag;
        end
        if ((r_state == S_POS_WAIT) && w_done[LANE_GAIN]) begin
            r_pos  <= w_pos;
            r_nxt  <= (w_pos == ADDR_W'(TABLE_SIZE)) ? w_pos : w_pos + ADDR_W'(1);
            // At the last entry both reads hit the same word, so the fraction
            // does not matter; zero keeps the product at zero.
            r_frac <= w_pos_clamp ? '0 : w_rem[LANE_GAIN];
        end
    end

    // Controller state register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Controller next state and strobes.
    always_comb begin
        n_state      = r_state;
        w_pos_start  = 1'b0;
        w_frac_start = 1'b0;
        w_raddr      = r_pos;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept && (i_item.mode == MODE_LOOKUP)) begin
                    n_state = S_POS;
                end
            end
            S_POS: begin
                w_pos_start = 1'b1;
                n_state     = S_POS_WAIT;
            end
            S_POS_WAIT: begin
                if (w_done[LANE_GAIN]) begin
                    n_state = S_RD_BASE;
                end
            end
            S_RD_BASE: begin
                w_raddr = r_pos;
                n_state = S_RD_NEXT;
            end
            S_RD_NEXT: begin
                w_raddr = r_nxt;
                n_state = S_DELTA;
            end
            S_DELTA: begin
                n_state = S_MULT;
            end
            S_MULT: begin
                n_state = S_FRAC;
            end
            S_FRAC: begin
                w_frac_start = 1'b1;
                n_state      = S_FRAC_WAIT;
            end
            S_FRAC_WAIT: begin
                if (&w_done) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Table memory, one word per position holding all three tables.
    assign w_wdata[LANE_GAIN]  = i_item.gain_entry;
    assign w_wdata[LANE_ALPHA] = i_item.alpha_entry;
    assign w_wdata[LANE_ATTEN] = i_item.atten_entry;

    tli_mem #(
        .DEPTH  (DEPTH),
        .ADDR_W (ADDR_W)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_load),
        .i_waddr (ADDR_W'(i_item.entry_index)),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // One interpolation lane per table; lane 0's divider also finds the position.
    for (genvar g = 0; g < NUM_TBL; g++) begin : g_lane
        logic [VAL_W-1:0]  r_base;
        logic              r_neg;
        logic [VAL_W-1:0]  r_mag;
        logic [PROD_W-1:0] r_prod;
        logic [VAL_W-1:0]  r_out;
        logic              w_start;
        logic [PROD_W-1:0] w_num;

        assign w_start = w_frac_start || ((g == LANE_GAIN) && w_pos_start);
        assign w_num   = ((g == LANE_GAIN) && (r_state == S_POS)) ? PROD_W'(r_dif) : r_prod;

        tli_div u_div (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_start (w_start),
            .i_num   (w_num),
            .i_den   (r_step),
            .o_done  (w_done[g]),
            .o_quo   (w_quo[g]),
            .o_rem   (w_rem[g])
        );

        // Base entry, signed difference to the next entry, product, result.
        always_ff @(posedge i_clk) begin
            if (r_state == S_RD_NEXT) begin
                r_base <= w_rdata[g];
            end
            if (r_state == S_DELTA) begin
                r_neg <= (w_rdata[g] < r_base);
                r_mag <= (w_rdata[g] < r_base) ? (r_base - w_rdata[g])
                                               : (w_rdata[g] - r_base);
            end
            if (r_state == S_MULT) begin
                r_prod <= PROD_W'(r_frac) * PROD_W'(r_mag);
            end
            if ((r_state == S_FRAC_WAIT) && w_done[g]) begin
                r_out <= r_neg ? (r_base - w_quo[g]) : (r_base + w_quo[g]);
            end
        end

        assign w_out_val[g] = r_out;
    end

    // Result strobe and tag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_result_valid <= 1'b0;
        end else begin
            r_result_valid <= (r_state == S_FRAC_WAIT) && (&w_done);
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_FRAC_WAIT) && (&w_done)) begin
            r_result_tag <= r_tag;
        end
    end

    assign o_result_valid      = r_result_valid;
    assign o_result.gain_out   = w_out_val[LANE_GAIN];
    assign o_result.alpha_out  = w_out_val[LANE_ALPHA];
    assign o_result.atten_out  = w_out_val[LANE_ATTEN];
    assign o_result.result_tag = r_result_tag;

endmodule
